>>> src/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// shared types and codes for the nfa string matcher
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int SYMBOL_W = 8;
    localparam int TARGET_W = 3;
    localparam int CFG_W    = 4;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_FEED  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [SYMBOL_W-1:0] label;
        logic [TARGET_W-1:0] target;
    } rel_entry_t;

endpackage

>>> src/nfa_string_matcher.sv
// ----------------------------------------------------------------------------
// nfa_string_matcher
// nondeterministic finite automaton over a byte string, relation table in a
// memory swept by one shared compare unit
//
//   channel  direction  handshake          content
//   s_       in         s_valid / s_ready  load, begin or feed request
//   m_       out        m_valid / m_ready  alive, verdict, accepted, active set
//   cfg_     in         cfg_we             states in use
//
// load, begin, unused action and a feed on a dead string go straight to the
// done state, a feed on a live string scans states_in_use*MAX_RELATIONS entries: the scan reads
// one table entry per cycle through one memory port
// after reset a clearing pass over all NUM_NODES*MAX_RELATIONS entries runs first
// s_ready is high only when idle; a request is taken while a result still waits
// a stalled result holds the block in its final state until m_ready
// ----------------------------------------------------------------------------
module nfa_string_matcher
    import nfa_pkg::*;
#(
    parameter int NUM_NODES     = 8,
    parameter int MAX_RELATIONS = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [2:0] s_source_node,
    input  logic [1:0] s_relation_slot,
    input  logic [7:0] s_symbol,
    input  logic [2:0] s_next_node,
    input  logic       s_relation_valid,
    input  logic       s_last_symbol,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_alive,
    output logic       m_verdict_ready,
    output logic       m_accepted,
    output logic [7:0] m_active_set
);

    localparam int TABLE_SIZE = NUM_NODES * MAX_RELATIONS;
    localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int NODE_W     = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int SLOT_W     = (MAX_RELATIONS > 1) ? $clog2(MAX_RELATIONS) : 1;
    localparam logic [CFG_W-1:0] STATES_RST =
        CFG_W'((NUM_NODES < 8) ? NUM_NODES : 8);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     states_reg;
    logic [NUM_NODES-1:0] active_reg, active_next;
    logic                 dead_reg, dead_next;
    logic [NUM_NODES-1:0] acc_reg, acc_next;

    logic [SYMBOL_W-1:0]  symbol_reg;
    logic                 verdict_reg;

    logic [ADDR_W-1:0]    addr_reg;
    logic [NODE_W-1:0]    node_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [NODE_W-1:0]    rd_node_reg;
    logic                 rd_vld_reg;

    rel_entry_t           mem [TABLE_SIZE];
    rel_entry_t           rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    rel_entry_t           mem_wdata;

    logic                 m_valid_reg;
    logic                 m_alive_reg;
    logic                 m_verdict_reg;
    logic                 m_accepted_reg;
    logic [7:0]           m_active_reg;

    logic                 in_fire;
    logic                 load_ok;
    logic                 clear_end;
    logic                 scan_end;
    logic                 slot_end;
    logic                 out_free;
    logic                 hit;
    logic [NUM_NODES-1:0] hit_vec;
    logic [NUM_NODES-1:0] shown;
    logic [NUM_NODES+7:0] shown_pad;
    logic                 shown_any;
    logic                 accept_bit;

    assign in_fire   = s_valid && s_ready;
    assign load_ok   = (int'(s_source_node) < NUM_NODES) &&
                       (int'(s_relation_slot) < MAX_RELATIONS);
    assign clear_end = (addr_reg == ADDR_W'(TABLE_SIZE - 1));
    assign slot_end  = (slot_reg == SLOT_W'(MAX_RELATIONS - 1));
    assign scan_end  = slot_end && (int'(node_reg) == int'(states_reg) - 1);
    assign out_free  = !m_valid_reg || m_ready;

    // compare unit
    always_comb begin
        hit = rd_vld_reg && rd_data_reg.valid && (rd_data_reg.label == symbol_reg) &&
              (int'(rd_data_reg.target) < int'(states_reg)) && active_reg[rd_node_reg];
        for (int n = 0; n < NUM_NODES; n++) begin
            hit_vec[n] = hit && (int'(rd_data_reg.target) == n);
        end
        acc_next = acc_reg | hit_vec;
    end

    // visible set and verdict
    always_comb begin
        accept_bit = 1'b0;
        for (int n = 0; n < NUM_NODES; n++) begin
            shown[n] = !dead_reg && active_reg[n] && (n < int'(states_reg));
            if (n + 1 == int'(states_reg)) begin
                accept_bit = shown[n];
            end
        end
        shown_any = |shown;
        shown_pad = {8'd0, shown};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clear_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (action_t'(s_action) == ACT_FEED && !dead_reg) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready     = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = '0;
        active_next = active_reg;
        dead_next   = dead_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && action_t'(s_action) == ACT_LOAD && load_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(int'(s_source_node) * MAX_RELATIONS +
                                        int'(s_relation_slot));
                    mem_wdata = '{valid: s_relation_valid, label: s_symbol,
                                  target: s_next_node};
                end
                if (s_valid && action_t'(s_action) == ACT_BEGIN) begin
                    active_next = NUM_NODES'(1);
                    dead_next   = 1'b0;
                end
            end
            ST_LAST: begin
                active_next = acc_next;
                dead_next   = (acc_next == '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            states_reg  <= STATES_RST;
            active_reg  <= NUM_NODES'(1);
            dead_reg    <= 1'b0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            dead_reg   <= dead_next;

            if (cfg_we) begin
                if (cfg_wdata == '0) begin
                    states_reg <= CFG_W'(1);
                end else if (int'(cfg_wdata) > NUM_NODES) begin
                    states_reg <= CFG_W'(NUM_NODES);
                end else begin
                    states_reg <= cfg_wdata;
                end
            end

            rd_vld_reg <= (state_reg == ST_SCAN);

            case (state_reg)
                ST_CLEAR: begin
                    addr_reg <= clear_end ? '0 : addr_reg + ADDR_W'(1);
                end
                ST_SCAN: begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                end
                default: addr_reg <= '0;
            endcase

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_node_reg <= node_reg;
        if (in_fire) begin
            symbol_reg  <= s_symbol;
            verdict_reg <= (action_t'(s_action) == ACT_BEGIN) ||
                           (action_t'(s_action) == ACT_FEED && s_last_symbol);
            acc_reg     <= '0;
            node_reg    <= '0;
            slot_reg    <= '0;
        end else if (state_reg == ST_SCAN) begin
            acc_reg <= acc_next;
            if (slot_end) begin
                slot_reg <= '0;
                node_reg <= node_reg + NODE_W'(1);
            end else begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_alive_reg    <= shown_any;
            m_verdict_reg  <= verdict_reg;
            m_accepted_reg <= verdict_reg && shown_any && accept_bit;
            m_active_reg   <= shown_pad[7:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_alive         = m_alive_reg;
    assign m_verdict_ready = m_verdict_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_active_set    = m_active_reg;

    // checks
    a_no_request_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request taken during clearing pass");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_LAST) |-> !mem_we)
        else $error("table written during scan");

    a_scan_feeds_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> rd_vld_reg)
        else $error("scan read not compared");

    a_accept_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_verdict_ready && m_alive))
        else $error("accepted without verdict or live string");

    a_dead_shows_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_alive) |-> (m_active_set == 8'd0))
        else $error("dead string shows active nodes");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for nfa_string_matcher: relation loads, begins and
// symbol feeds go in over a valid/ready channel with random gaps. A model
// of the automaton in this file predicts each result (directed rows may
// carry their own), and every result is compared field by field in order.
// A directed table comes first, then random phases of strings over small
// alphabets, each after its own states-in-use write. One phase has a long
// result stall and one has no gaps at all.
// ----------------------------------------------------------------------------
module testbench;
    import nfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        action_t    action;
        logic [2:0] src;
        logic [1:0] slot;
        logic [7:0] sym;
        logic [2:0] nxt;
        logic       rvalid;
        logic       last;
    } item_t;

    typedef struct packed {
        logic       alive;
        logic       verdict_ready;
        logic       accepted;
        logic [7:0] active_set;
    } match_result_t;

    typedef struct packed {
        item_t         item;
        bit            typed;
        match_result_t want;
    } request_t;

    typedef struct packed {
        bit         cfg_write;
        logic [3:0] cfg_value;
        action_t    action;
        logic [2:0] src;
        logic [1:0] slot;
        logic [7:0] sym;
        logic [2:0] nxt;
        logic       rvalid;
        logic       last;
        bit         typed;
        logic       alive;
        logic       verdict_ready;
        logic       accepted;
        logic [7:0] active_set;
    } dir_row_t;

    logic       aclk;
    logic       aresetn          = 1'b0;
    logic       cfg_we           = 1'b0;
    logic [3:0] cfg_wdata        = 4'd0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [1:0] s_action         = 2'd0;
    logic [2:0] s_source_node    = 3'd0;
    logic [1:0] s_relation_slot  = 2'd0;
    logic [7:0] s_symbol         = 8'd0;
    logic [2:0] s_next_node      = 3'd0;
    logic       s_relation_valid = 1'b0;
    logic       s_last_symbol    = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic       m_alive;
    logic       m_verdict_ready;
    logic       m_accepted;
    logic [7:0] m_active_set;

    request_t      request_q[$];
    match_result_t verdict_q[$];
    request_t      cur_req;

    logic       rel_valid  [32];
    logic [7:0] rel_label  [32];
    logic [2:0] rel_target [32];
    logic [7:0] live_nodes;
    logic       string_killed;
    int         node_count;

    int  err_count   = 0;
    int  idle_cycles = 0;
    int  hold_left   = 0;
    bit  quiet       = 1'b0;
    bit  stall_req   = 1'b0;

    dir_row_t   dir_table [DIR_ROWS];
    logic [7:0] alphabet  [4];

    nfa_string_matcher uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_source_node    (s_source_node),
        .s_relation_slot  (s_relation_slot),
        .s_symbol         (s_symbol),
        .s_next_node      (s_next_node),
        .s_relation_valid (s_relation_valid),
        .s_last_symbol    (s_last_symbol),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_alive          (m_alive),
        .m_verdict_ready  (m_verdict_ready),
        .m_accepted       (m_accepted),
        .m_active_set     (m_active_set)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic match_result_t match_step(item_t it);
        match_result_t r;
        logic [7:0]    next_set;
        logic [7:0]    mask;
        logic [7:0]    shown;
        logic [4:0]    idx;
        r        = '0;
        next_set = 8'h00;
        case (it.action)
            ACT_LOAD: begin
                idx             = {it.src, it.slot};
                rel_valid[idx]  = it.rvalid;
                rel_label[idx]  = it.sym;
                rel_target[idx] = it.nxt;
            end
            ACT_BEGIN: begin
                live_nodes      = 8'h01;
                string_killed   = 1'b0;
                r.verdict_ready = 1'b1;
            end
            ACT_FEED: begin
                if (!string_killed) begin
                    for (int n = 0; n < node_count; n++) begin
                        if (live_nodes[n]) begin
                            for (int k = 0; k < 4; k++) begin
                                idx = 5'(n * 4 + k);
                                if (rel_valid[idx] && rel_label[idx] == it.sym &&
                                    int'(rel_target[idx]) < node_count) begin
                                    next_set[rel_target[idx]] = 1'b1;
                                end
                            end
                        end
                    end
                    live_nodes = next_set;
                    if (next_set == 8'h00) string_killed = 1'b1;
                end
                r.verdict_ready = it.last;
            end
            default: ;
        endcase
        mask         = 8'((9'd1 << node_count) - 9'd1);
        shown        = string_killed ? 8'h00 : (live_nodes & mask);
        r.alive      = (shown != 8'h00);
        r.active_set = shown;
        if (r.verdict_ready) r.accepted = r.alive && shown[3'(node_count - 1)];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic send_item(input action_t a, input logic [2:0] src, input logic [1:0] slot,
                             input logic [7:0] sym, input logic [2:0] nxt,
                             input logic rv, input logic last);
        request_t req;
        req             = '0;
        req.item.action = a;
        req.item.src    = src;
        req.item.slot   = slot;
        req.item.sym    = sym;
        req.item.nxt    = nxt;
        req.item.rvalid = rv;
        req.item.last   = last;
        request_q.push_back(req);
    endtask

    task automatic send_load();
        logic [2:0] src;
        logic [2:0] nxt;
        logic [7:0] sym;
        src = ($urandom_range(99) < 80) ? 3'($urandom_range(node_count - 1))
                                        : 3'($urandom_range(7));
        nxt = ($urandom_range(99) < 80) ? 3'($urandom_range(node_count - 1))
                                        : 3'($urandom_range(7));
        sym = ($urandom_range(9) != 0) ? alphabet[2'($urandom_range(3))]
                                       : 8'($urandom_range(255));
        send_item(ACT_LOAD, src, 2'($urandom_range(3)), sym, nxt,
                  1'($urandom_range(99) < 85), 1'($urandom_range(1)));
    endtask

    task automatic wait_idle();
        while (!(request_q.size() == 0 && !s_valid && verdict_q.size() == 0))
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_states(input logic [3:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        node_count = (v == 4'd0) ? 1 : (v > 4'd8) ? 8 : int'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // request channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                match_result_t r;
                r = match_step(cur_req.item);
                verdict_q.push_back(cur_req.typed ? cur_req.want : r);
            end
            if (!s_valid || s_ready) begin
                if (request_q.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
                    cur_req           = request_q.pop_front();
                    s_valid          <= 1'b1;
                    s_action         <= cur_req.item.action;
                    s_source_node    <= cur_req.item.src;
                    s_relation_slot  <= cur_req.item.slot;
                    s_symbol         <= cur_req.item.sym;
                    s_next_node      <= cur_req.item.nxt;
                    s_relation_valid <= cur_req.item.rvalid;
                    s_last_symbol    <= cur_req.item.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result channel back pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 12);
            end
        end
    end

    always @(posedge aclk) begin
        match_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_active_set, 8'h00);
            end else begin
                want = verdict_q.pop_front();
                if (m_alive !== want.alive)
                    report_mismatch("alive", 8'(m_alive), 8'(want.alive));
                if (m_verdict_ready !== want.verdict_ready)
                    report_mismatch("verdict_ready", 8'(m_verdict_ready),
                                    8'(want.verdict_ready));
                if (m_accepted !== want.accepted)
                    report_mismatch("accepted", 8'(m_accepted), 8'(want.accepted));
                if (m_active_set !== want.active_set)
                    report_mismatch("active_set", m_active_set, want.active_set);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: no request or result accepted for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        request_t   req;
        dir_row_t   row;
        logic [3:0] cfg_v;
        int         sent;
        int         len;
        int         n;

        for (int i = 0; i < 32; i++) begin
            rel_valid[i]  = 1'b0;
            rel_label[i]  = 8'h00;
            rel_target[i] = 3'd0;
        end
        live_nodes    = 8'h01;
        string_killed = 1'b0;
        node_count    = 8;

        //             cfg     action     src slot sym    nxt rv last typ al vr ac set
        dir_table[0]  = '{1, 8,  ACT_LOAD,  0, 0, 8'h41, 1, 1, 0, 1, 1, 0, 0, 8'h01};
        dir_table[1]  = '{0, 0,  ACT_NONE,  7, 3, 8'hff, 7, 1, 1, 1, 1, 0, 0, 8'h01};
        dir_table[2]  = '{0, 0,  ACT_LOAD,  7, 3, 8'hff, 7, 1, 0, 1, 1, 0, 0, 8'h01};
        dir_table[3]  = '{0, 0,  ACT_LOAD,  1, 1, 8'h00, 7, 1, 0, 0, 0, 0, 0, 8'h00};
        dir_table[4]  = '{0, 0,  ACT_LOAD,  0, 3, 8'h41, 2, 1, 0, 0, 0, 0, 0, 8'h00};
        dir_table[5]  = '{0, 0,  ACT_LOAD,  0, 2, 8'h42, 3, 0, 0, 0, 0, 0, 0, 8'h00};
        dir_table[6]  = '{0, 0,  ACT_BEGIN, 0, 0, 8'h00, 0, 0, 0, 1, 1, 1, 0, 8'h01};
        dir_table[7]  = '{0, 0,  ACT_FEED,  0, 0, 8'h41, 0, 0, 0, 0, 0, 0, 0, 8'h00};
        dir_table[8]  = '{0, 0,  ACT_FEED,  0, 0, 8'h00, 0, 0, 1, 0, 0, 0, 0, 8'h00};
        dir_table[9]  = '{0, 0,  ACT_FEED,  0, 0, 8'hff, 0, 0, 0, 0, 0, 0, 0, 8'h00};
        dir_table[10] = '{0, 0,  ACT_FEED,  0, 0, 8'h42, 0, 0, 1, 0, 0, 0, 0, 8'h00};
        dir_table[11] = '{0, 0,  ACT_FEED,  0, 0, 8'h41, 0, 0, 1, 1, 0, 1, 0, 8'h00};
        dir_table[12] = '{0, 0,  ACT_FEED,  0, 0, 8'h41, 0, 0, 0, 1, 0, 0, 0, 8'h00};
        dir_table[13] = '{0, 0,  ACT_LOAD,  2, 0, 8'h55, 6, 1, 0, 0, 0, 0, 0, 8'h00};
        dir_table[14] = '{0, 0,  ACT_BEGIN, 0, 0, 8'h00, 0, 0, 0, 1, 1, 1, 0, 8'h01};
        dir_table[15] = '{0, 0,  ACT_FEED,  0, 0, 8'h41, 0, 0, 0, 0, 0, 0, 0, 8'h00};
        dir_table[16] = '{1, 2,  ACT_FEED,  0, 0, 8'h55, 0, 0, 1, 0, 0, 0, 0, 8'h00};
        dir_table[17] = '{1, 1,  ACT_BEGIN, 0, 0, 8'h00, 0, 0, 0, 1, 1, 1, 1, 8'h01};
        dir_table[18] = '{0, 0,  ACT_FEED,  0, 0, 8'h41, 0, 0, 1, 0, 0, 0, 0, 8'h00};
        dir_table[19] = '{1, 0,  ACT_BEGIN, 0, 0, 8'h00, 0, 0, 0, 1, 1, 1, 1, 8'h01};
        dir_table[20] = '{1, 15, ACT_LOAD,  7, 3, 8'h00, 0, 1, 0, 0, 0, 0, 0, 8'h00};
        dir_table[21] = '{0, 0,  ACT_BEGIN, 0, 0, 8'h00, 0, 0, 0, 1, 1, 1, 0, 8'h01};
        dir_table[22] = '{0, 0,  ACT_FEED,  0, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 8'h00};
        dir_table[23] = '{0, 0,  ACT_NONE,  0, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 8'h00};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_table[i];
            if (row.cfg_write) begin
                wait_idle();
                write_states(row.cfg_value);
            end
            req                    = '0;
            req.item.action        = row.action;
            req.item.src           = row.src;
            req.item.slot          = row.slot;
            req.item.sym           = row.sym;
            req.item.nxt           = row.nxt;
            req.item.rvalid        = row.rvalid;
            req.item.last          = row.last;
            req.typed              = row.typed;
            req.want.alive         = row.alive;
            req.want.verdict_ready = row.verdict_ready;
            req.want.accepted      = row.accepted;
            req.want.active_set    = row.active_set;
            request_q.push_back(req);
        end

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            quiet = 1'b0;
            cfg_v = (phase == 0) ? 4'd3 : (phase == 1) ? 4'd15 : 4'($urandom_range(15));
            write_states(cfg_v);
            for (int j = 0; j < 4; j++) alphabet[j] = 8'($urandom_range(255));
            quiet = (phase == 4);
            if (phase == 3) stall_req = 1'b1;
            for (int j = 0; j < 12; j++) send_load();
            sent = 12;
            while (sent < 100) begin
                if ($urandom_range(99) < 75) begin
                    n = $urandom_range(2);
                    repeat (n) send_load();
                    send_item(ACT_BEGIN, 3'($urandom_range(7)), 2'($urandom_range(3)),
                              8'($urandom_range(255)), 3'($urandom_range(7)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                    len = $urandom_range(6, 1);
                    for (int k = 0; k < len; k++) begin
                        send_item(ACT_FEED, 3'($urandom_range(7)), 2'($urandom_range(3)),
                                  ($urandom_range(9) != 0) ? alphabet[2'($urandom_range(3))]
                                                           : 8'($urandom_range(255)),
                                  3'($urandom_range(7)), 1'($urandom_range(1)),
                                  1'(k == len - 1));
                    end
                    sent += n + 1 + len;
                end else begin
                    send_item(action_t'($urandom_range(3)), 3'($urandom_range(7)),
                              2'($urandom_range(3)), 8'($urandom_range(255)),
                              3'($urandom_range(7)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                    sent++;
                end
            end
        end

        while (!(request_q.size() == 0 && !s_valid && verdict_q.size() == 0))
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/nfa_pkg.sv
src/nfa_string_matcher.sv
sim/testbench.sv
